// ===== rtl/mdpf_pkg.sv =====
// Shared types, frame constants and the CRC-16/XMODEM byte update for the duty framer.
package mdpf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DUTY_W   = 16;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned POS_W    = 3;

    localparam logic [BYTE_W-1:0] CMD_SET_DUTY  = 8'd34;
    localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT      = 16'h0000;
    localparam logic [BYTE_W-1:0] ADDR_RESET    = 8'd128;

    // Byte positions within one frame, in transmit order
    localparam logic [POS_W-1:0] POS_ADDR     = 3'd0;
    localparam logic [POS_W-1:0] POS_CMD      = 3'd1;
    localparam logic [POS_W-1:0] POS_LEFT_HI  = 3'd2;
    localparam logic [POS_W-1:0] POS_LEFT_LO  = 3'd3;
    localparam logic [POS_W-1:0] POS_RIGHT_HI = 3'd4;
    localparam logic [POS_W-1:0] POS_RIGHT_LO = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC_HI   = 3'd6;
    localparam logic [POS_W-1:0] POS_CRC_LO   = 3'd7;

    // One command waiting to be framed
    typedef struct packed {
        logic [BYTE_W-1:0] addr;
        logic [DUTY_W-1:0] left;
        logic [DUTY_W-1:0] right;
    } mdpf_item_t;

    // Fold one byte into the CRC, MSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (crc[CRC_W-1])
            begin
                crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[CRC_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/mdpf_serializer.sv =====
// Frame serializer: walks the eight frame bytes, folds the CRC, drives the output register.
module mdpf_serializer
    import mdpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  mdpf_item_t        item,
    output logic              item_take,
    output logic              tx_valid,
    input  logic              tx_stall,
    output logic [BYTE_W-1:0] tx_byte,
    output logic              frame_end
);

    logic              busy_reg, busy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    mdpf_item_t        frm_reg, frm_next;
    logic              tx_valid_reg, tx_valid_next;
    logic [BYTE_W-1:0] tx_byte_reg, tx_byte_next;
    logic              frame_end_reg, frame_end_next;

    logic              advance;
    logic              finish;
    logic              load;
    logic [BYTE_W-1:0] cur_byte;

    // Move a beat into the output register when it is empty or being taken
    assign advance   = !tx_valid_reg || !tx_stall;
    assign finish    = busy_reg && advance && (pos_reg == POS_CRC_LO);
    assign load      = item_valid && (!busy_reg || finish);
    assign item_take = load;

    // Pick the byte for the current position
    always_comb
    begin
        case (pos_reg)
            POS_ADDR:     cur_byte = frm_reg.addr;
            POS_CMD:      cur_byte = CMD_SET_DUTY;
            POS_LEFT_HI:  cur_byte = frm_reg.left[DUTY_W-1 -: BYTE_W];
            POS_LEFT_LO:  cur_byte = frm_reg.left[BYTE_W-1:0];
            POS_RIGHT_HI: cur_byte = frm_reg.right[DUTY_W-1 -: BYTE_W];
            POS_RIGHT_LO: cur_byte = frm_reg.right[BYTE_W-1:0];
            POS_CRC_HI:   cur_byte = crc_reg[CRC_W-1 -: BYTE_W];
            POS_CRC_LO:   cur_byte = crc_reg[BYTE_W-1:0];
            default:      cur_byte = '0;
        endcase
    end

    // Advance position and CRC; load a new frame when idle or as the last byte leaves
    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        frm_next  = frm_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = POS_ADDR;
            crc_next  = CRC_INIT;
            frm_next  = item;
        end
        else if (busy_reg && advance)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == POS_CRC_LO)
            begin
                busy_next = 1'b0;
            end
            if (pos_reg < POS_CRC_HI)
            begin
                crc_next = crc_byte(crc_reg, cur_byte);
            end
        end
    end

    // Output register
    always_comb
    begin
        tx_valid_next  = tx_valid_reg;
        tx_byte_next   = tx_byte_reg;
        frame_end_next = frame_end_reg;
        if (advance)
        begin
            tx_valid_next  = busy_reg;
            tx_byte_next   = cur_byte;
            frame_end_next = (pos_reg == POS_CRC_LO);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pos_reg      <= POS_ADDR;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pos_reg      <= pos_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        crc_reg       <= crc_next;
        frm_reg       <= frm_next;
        tx_byte_reg   <= tx_byte_next;
        frame_end_reg <= frame_end_next;
    end

    assign tx_valid  = tx_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== rtl/motor_duty_packet_framer.sv =====
// Top level of the motor duty packet framer: address register, command buffer, serializer.
//
// Usage:
//   cmd channel: one beat carries a left and right signed 16-bit duty value.
//   tx channel : each command yields eight byte beats in transmit order:
//                address, command 34, left hi/lo, right hi/lo, CRC hi/lo.
//                frame_end marks the CRC low byte. The CRC is CRC-16/XMODEM.
//   cfg channel: cfg_data writes the device address; cfg_ready is always high.
//                Write it only while no frame is pending.
// Path: a command passes through the command buffer, the serializer frame
//   registers and the output register before its first byte reaches tx.
// Overlap: a one-entry command buffer takes the next command while the
//   current frame is still going out, so frames follow with no gap while
//   tx_stall is low.
// Reset: the address returns to 128, the buffer and serializer empty.
// Stall: a high tx_stall holds the output byte; once the buffer is full,
//   cmd_stall stays high until the serializer takes the buffered command.
module motor_duty_packet_framer
    import mdpf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic signed [DUTY_W-1:0] left_duty,
    input  logic signed [DUTY_W-1:0] right_duty,
    output logic                     tx_valid,
    input  logic                     tx_stall,
    output logic        [BYTE_W-1:0] tx_byte,
    output logic                     frame_end,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic        [BYTE_W-1:0] cfg_data
);

    logic [BYTE_W-1:0] addr_reg, addr_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [DUTY_W-1:0] hold_left_reg, hold_left_next;
    logic [DUTY_W-1:0] hold_right_reg, hold_right_next;

    logic              cmd_accept;
    logic              item_take;
    mdpf_item_t        item;

    // Configuration write
    assign cfg_ready = 1'b1;

    always_comb
    begin
        addr_next = addr_reg;
        if (cfg_valid && cfg_ready)
        begin
            addr_next = cfg_data;
        end
    end

    // Command buffer: fill on accept, drain when the serializer takes it
    assign cmd_stall  = hold_valid_reg;
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_left_next  = hold_left_reg;
        hold_right_next = hold_right_reg;
        if (cmd_accept)
        begin
            hold_valid_next = 1'b1;
            hold_left_next  = left_duty;
            hold_right_next = right_duty;
        end
        else if (item_take)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= ADDR_RESET;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_left_reg  <= hold_left_next;
        hold_right_reg <= hold_right_next;
    end

    assign item.addr  = addr_reg;
    assign item.left  = hold_left_reg;
    assign item.right = hold_right_reg;

    mdpf_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (hold_valid_reg),
        .item       (item),
        .item_take  (item_take),
        .tx_valid   (tx_valid),
        .tx_stall   (tx_stall),
        .tx_byte    (tx_byte),
        .frame_end  (frame_end)
    );

endmodule

// ===== rtl/mdpf_checker.sv =====
// Port-level checker for the duty framer, bound to the top level.
module mdpf_checker
    import mdpf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input logic              tx_valid,
    input logic              tx_stall,
    input logic [BYTE_W-1:0] tx_byte,
    input logic              frame_end
);

    logic [POS_W-1:0] beat_cnt_reg, beat_cnt_next;

    // Count tx beats within a frame
    always_comb
    begin
        beat_cnt_next = beat_cnt_reg;
        if (tx_valid && !tx_stall)
        begin
            beat_cnt_next = beat_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= POS_ADDR;
        end
        else
        begin
            beat_cnt_reg <= beat_cnt_next;
        end
    end

    // A stalled byte holds
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_stall |=> tx_valid && $stable(tx_byte) && $stable(frame_end))
        else $error("tx beat changed while stalled");

    // frame_end marks exactly every eighth byte
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> (frame_end == (beat_cnt_reg == POS_CRC_LO)))
        else $error("frame_end out of place");

    // Second byte of each frame is the command code
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (beat_cnt_reg == POS_CMD) |-> (tx_byte == CMD_SET_DUTY))
        else $error("wrong command code");

    // An accepted command fills the one-entry buffer
    a_buf_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command buffer did not fill");

endmodule

bind motor_duty_packet_framer mdpf_checker u_mdpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .tx_valid  (tx_valid),
    .tx_stall  (tx_stall),
    .tx_byte   (tx_byte),
    .frame_end (frame_end)
);
